>>> hw/rtl/isnf_pkg.sv
`default_nettype none
package isnf_pkg;
   localparam int MaxRuns = 64;
   localparam int PosBits = 32;
   localparam int IdxBits = $clog2(MaxRuns);
   localparam int CntBits = $clog2(MaxRuns + 1);
   localparam logic [PosBits-1:0] PosTop = {PosBits{1'b1}};

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_MARK  = 2'd1,
      OP_NEXT  = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_COVERED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_RANGE    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      logic                 rd_en;
      logic [IdxBits-1:0]   rd_addr;
      logic                 wr_en;
      logic [IdxBits-1:0]   wr_addr;
      logic [PosBits-1:0]   wr_start;
      logic [PosBits-1:0]   wr_end;
   } dp_cmd_type;

   typedef struct packed {
      logic [PosBits-1:0]   rd_start;
      logic [PosBits-1:0]   rd_end;
   } dp_status_type;
endpackage
`default_nettype wire

>>> hw/rtl/isnf_if.sv
`default_nettype none
interface isnf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] position;
   logic [5:0]  run_index;
   modport source (output valid, opcode, position, run_index, input ready);
   modport sink (input valid, opcode, position, run_index, output ready);
endinterface

interface isnf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [31:0] run_end;
   logic [6:0]  run_count;
   logic [2:0]  status;
   modport source (output valid, value, run_end, run_count, status, input ready);
   modport sink (input valid, value, run_end, run_count, status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/isnf_ram.sv
`default_nettype none
module isnf_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/isnf_datapath.sv
`default_nettype none
module isnf_datapath (
   input  wire logic                  clock,
   input  wire isnf_pkg::dp_cmd_type  cmd,
   output isnf_pkg::dp_status_type    stat
);
   logic [isnf_pkg::PosBits-1:0] rd_start;
   logic [isnf_pkg::PosBits-1:0] rd_end;

   isnf_ram #(.Width(isnf_pkg::PosBits), .Depth(isnf_pkg::MaxRuns)) u_starts (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_start),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_start)
   );

   isnf_ram #(.Width(isnf_pkg::PosBits), .Depth(isnf_pkg::MaxRuns)) u_ends (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_end),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_end)
   );

   assign stat.rd_start = rd_start;
   assign stat.rd_end   = rd_end;
endmodule
`default_nettype wire

>>> hw/rtl/isnf_ctrl.sv
`default_nettype none
module isnf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   isnf_req_if.sink                     req,
   isnf_rsp_if.source                   rsp,
   output isnf_pkg::dp_cmd_type         cmd,
   input  wire isnf_pkg::dp_status_type stat
);
   localparam int P = isnf_pkg::PosBits;
   localparam int I = isnf_pkg::IdxBits;
   localparam int C = isnf_pkg::CntBits;
   localparam logic [C-1:0] CntMax = C'(isnf_pkg::MaxRuns);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_RD_RIGHT, S_RIGHT_WAIT,
      S_RIGHT_CHECK, S_SHIFT_RD, S_SHIFT_WAIT, S_RESP
   } state_type;

   state_type state_ff, state_in;
   isnf_pkg::opcode_type op_ff, op_in;
   logic [P-1:0] pos_ff, pos_in;
   logic [C-1:0] held_ff, held_in;
   logic [C-1:0] k_ff, k_in;
   logic [C-1:0] ptr_ff, ptr_in;
   logic [P-1:0] lend_ff, lend_in;
   logic [P-1:0] lstart_ff, lstart_in;
   logic         fuse_ff, fuse_in;
   logic [31:0]  value_ff, value_in;
   logic [31:0]  rend_ff, rend_in;
   isnf_pkg::status_type st_ff, st_in;
   logic         rvalid_ff, rvalid_in;
   logic         right_c;
   isnf_pkg::dp_cmd_type cmd_c;

   assign req.ready     = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp.valid     = rvalid_ff;
   assign rsp.value     = value_ff;
   assign rsp.run_end   = rend_ff;
   assign rsp.run_count = 7'(held_ff);
   assign rsp.status    = st_ff;
   assign cmd           = cmd_c;
   assign right_c       = (state_ff == S_RIGHT_WAIT) && (stat.rd_start == pos_ff + P'(1));

   always_comb begin
      state_in = state_ff; op_in = op_ff; pos_in = pos_ff;
      held_in = held_ff; k_in = k_ff; ptr_in = ptr_ff; lend_in = lend_ff;
      lstart_in = lstart_ff; fuse_in = fuse_ff; value_in = value_ff;
      rend_in = rend_ff; st_in = st_ff; rvalid_in = rvalid_ff;
      cmd_c = '0;
      if (rvalid_ff && rsp.ready) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && !rvalid_ff) begin
               op_in = isnf_pkg::opcode_type'(req.opcode);
               pos_in = P'(req.position);
               value_in = '0; rend_in = '0; st_in = isnf_pkg::ST_OK;
               k_in = '0; fuse_in = 1'b0;
               case (isnf_pkg::opcode_type'(req.opcode))
                  isnf_pkg::OP_CLEAR: begin
                     held_in = '0;
                     state_in = S_RESP;
                  end
                  isnf_pkg::OP_READ: begin
                     if (C'(req.run_index) >= held_ff) begin
                        st_in = isnf_pkg::ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        cmd_c.rd_en = 1'b1;
                        cmd_c.rd_addr = I'(req.run_index);
                        state_in = S_SCAN_WAIT;
                     end
                  end
                  isnf_pkg::OP_NEXT: begin
                     if (P'(req.position) == isnf_pkg::PosTop) begin
                        st_in = isnf_pkg::ST_OVERFLOW;
                        state_in = S_RESP;
                     end else begin
                        pos_in = P'(req.position) + P'(1);
                        state_in = S_SCAN;
                     end
                  end
                  default: state_in = S_SCAN;
               endcase
            end
         end
         S_SCAN: begin
            if (k_ff < held_ff) begin
               cmd_c.rd_en = 1'b1;
               cmd_c.rd_addr = I'(k_ff);
               state_in = S_SCAN_WAIT;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_SCAN_WAIT: begin
            if (op_ff == isnf_pkg::OP_READ) begin
               value_in = 32'(stat.rd_start);
               rend_in = 32'(stat.rd_end);
               state_in = S_RESP;
            end else if (stat.rd_start <= pos_ff) begin
               lstart_in = stat.rd_start;
               lend_in = stat.rd_end;
               k_in = k_ff + C'(1);
               state_in = S_SCAN;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (op_ff == isnf_pkg::OP_NEXT) begin
               if (k_ff != '0 && lend_ff >= pos_ff) begin
                  if (lend_ff == isnf_pkg::PosTop) begin
                     st_in = isnf_pkg::ST_OVERFLOW;
                  end else begin
                     value_in = 32'(lend_ff + P'(1));
                  end
               end else begin
                  value_in = 32'(pos_ff);
               end
               state_in = S_RESP;
            end else if (k_ff != '0 && lend_ff >= pos_ff) begin
               st_in = isnf_pkg::ST_COVERED;
               state_in = S_RESP;
            end else begin
               fuse_in = (k_ff != '0) && (lend_ff + P'(1) == pos_ff);
               state_in = S_RD_RIGHT;
            end
         end
         S_RD_RIGHT: begin
            if (pos_ff != isnf_pkg::PosTop && k_ff < held_ff) begin
               cmd_c.rd_en = 1'b1;
               cmd_c.rd_addr = I'(k_ff);
               state_in = S_RIGHT_WAIT;
            end else begin
               state_in = S_RIGHT_CHECK;
            end
         end
         S_RIGHT_WAIT, S_RIGHT_CHECK: begin
            if (fuse_ff && right_c) begin
               cmd_c.wr_en = 1'b1;
               cmd_c.wr_addr = I'(k_ff - C'(1));
               cmd_c.wr_start = lstart_ff;
               cmd_c.wr_end = stat.rd_end;
               ptr_in = k_ff;
               held_in = held_ff - C'(1);
               state_in = S_SHIFT_RD;
            end else if (fuse_ff) begin
               cmd_c.wr_en = 1'b1;
               cmd_c.wr_addr = I'(k_ff - C'(1));
               cmd_c.wr_start = lstart_ff;
               cmd_c.wr_end = pos_ff;
               state_in = S_RESP;
            end else if (right_c) begin
               cmd_c.wr_en = 1'b1;
               cmd_c.wr_addr = I'(k_ff);
               cmd_c.wr_start = pos_ff;
               cmd_c.wr_end = stat.rd_end;
               state_in = S_RESP;
            end else if (held_ff == CntMax) begin
               st_in = isnf_pkg::ST_FULL;
               state_in = S_RESP;
            end else begin
               ptr_in = held_ff;
               held_in = held_ff + C'(1);
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (fuse_ff) begin
               if (ptr_ff < held_ff) begin
                  cmd_c.rd_en = 1'b1;
                  cmd_c.rd_addr = I'(ptr_ff + C'(1));
                  state_in = S_SHIFT_WAIT;
               end else begin
                  state_in = S_RESP;
               end
            end else if (ptr_ff > k_ff) begin
               cmd_c.rd_en = 1'b1;
               cmd_c.rd_addr = I'(ptr_ff - C'(1));
               state_in = S_SHIFT_WAIT;
            end else begin
               cmd_c.wr_en = 1'b1;
               cmd_c.wr_addr = I'(k_ff);
               cmd_c.wr_start = pos_ff;
               cmd_c.wr_end = pos_ff;
               state_in = S_RESP;
            end
         end
         S_SHIFT_WAIT: begin
            cmd_c.wr_en = 1'b1;
            cmd_c.wr_addr = I'(ptr_ff);
            cmd_c.wr_start = stat.rd_start;
            cmd_c.wr_end = stat.rd_end;
            ptr_in = fuse_ff ? ptr_ff + C'(1) : ptr_ff - C'(1);
            state_in = S_SHIFT_RD;
         end
         S_RESP: begin
            rvalid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         rvalid_ff <= rvalid_in;
      end
      op_ff <= op_in; pos_ff <= pos_in; k_ff <= k_in;
      ptr_ff <= ptr_in; lend_ff <= lend_in; lstart_ff <= lstart_in;
      fuse_ff <= fuse_in; value_ff <= value_in; rend_ff <= rend_in; st_ff <= st_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/interval_set_mark_and_next_free_core.sv
// Clear and an out-of-range read run answer without reading the run table; a read run
// reads one entry. Next free and mark scan the runs in order up to the first run that
// starts after the position searched; marks that are not covered then read the run to
// the right and move runs on insert or fuse. One transfer at a time: a request is taken
// only when idle with no result pending, and each run table memory has a single read port.
// Reset: synchronous; the run count clears to zero, table contents are kept.
`default_nettype none
module interval_set_mark_and_next_free_core (
   input wire logic   clock,
   input wire logic   reset,
   isnf_req_if.sink   req,
   isnf_rsp_if.source rsp
);
   isnf_pkg::dp_cmd_type    cmd;
   isnf_pkg::dp_status_type stat;

   isnf_ctrl u_ctrl (
      .clock (clock), .reset (reset), .req (req), .rsp (rsp),
      .cmd (cmd), .stat (stat)
   );

   isnf_datapath u_dp (.clock (clock), .cmd (cmd), .stat (stat));

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp.run_count <= 7'(isnf_pkg::MaxRuns)) else $error("run count out of range");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request taken while result pending");
   a_full_value: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != 3'(isnf_pkg::ST_OK) |-> rsp.value == '0)
      else $error("nonzero value on error");
endmodule
`default_nettype wire

>>> tb/isnf_tb_pkg.sv
`default_nettype none
package isnf_tb_pkg;
   import isnf_pkg::*;

   class run_table_scoreboard;
      logic [PosBits-1:0] starts[MaxRuns];
      logic [PosBits-1:0] ends[MaxRuns];
      int unsigned        held;
      logic [31:0]        want_value[$];
      logic [31:0]        want_end[$];
      logic [6:0]         want_count[$];
      status_type         want_status[$];
      int                 errors;
      int                 checked;

      function new();
         held = 0;
         errors = 0;
         checked = 0;
      endfunction

      function int unsigned runs_at_or_below(logic [PosBits:0] p);
         int unsigned k;
         k = 0;
         while (k < held && {1'b0, starts[k]} <= p) k++;
         return k;
      endfunction

      function status_type mark_position(logic [PosBits-1:0] p);
         int unsigned k;
         bit          joins_left;
         bit          joins_right;
         k = runs_at_or_below({1'b0, p});
         if (k > 0 && ends[k-1] >= p) return ST_COVERED;
         joins_left = (k > 0) && ({1'b0, ends[k-1]} + 1 == {1'b0, p});
         joins_right = (p != PosTop) && (k < held) && (starts[k] == p + 1);
         if (joins_left && joins_right) begin
            ends[k-1] = ends[k];
            for (int i = k; i + 1 < held; i++) begin
               starts[i] = starts[i+1];
               ends[i] = ends[i+1];
            end
            held--;
         end else if (joins_left) begin
            ends[k-1] = p;
         end else if (joins_right) begin
            starts[k] = p;
         end else begin
            if (held >= MaxRuns) return ST_FULL;
            for (int i = held; i > k; i--) begin
               starts[i] = starts[i-1];
               ends[i] = ends[i-1];
            end
            starts[k] = p;
            ends[k] = p;
            held++;
         end
         return ST_OK;
      endfunction

      function void note_request(opcode_type op, logic [31:0] pos, logic [5:0] idx);
         logic [31:0]   v;
         logic [31:0]   e;
         status_type    st;
         int unsigned   k;
         v = '0;
         e = '0;
         st = ST_OK;
         case (op)
            OP_CLEAR: held = 0;
            OP_MARK: st = mark_position(pos);
            OP_NEXT: begin
               if (pos == PosTop) begin
                  st = ST_OVERFLOW;
               end else begin
                  k = runs_at_or_below({1'b0, pos} + 1);
                  if (k > 0 && ends[k-1] >= pos + 1) begin
                     if (ends[k-1] == PosTop) st = ST_OVERFLOW;
                     else v = ends[k-1] + 1;
                  end else begin
                     v = pos + 1;
                  end
               end
            end
            default: begin
               if (idx >= held) begin
                  st = ST_RANGE;
               end else begin
                  v = starts[idx];
                  e = ends[idx];
               end
            end
         endcase
         want_value.insert(want_value.size(), v);
         want_end.insert(want_end.size(), e);
         want_count.insert(want_count.size(), 7'(held));
         want_status.insert(want_status.size(), st);
      endfunction

      function void check_response(logic [31:0] v, logic [31:0] e, logic [6:0] c,
                                   logic [2:0] s);
         logic [31:0] xv;
         logic [31:0] xe;
         logic [6:0]  xc;
         status_type  xs;
         if (want_value.size() == 0) begin
            $error("response transfer with nothing outstanding");
            errors++;
            return;
         end
         xv = want_value.pop_front();
         xe = want_end.pop_front();
         xc = want_count.pop_front();
         xs = want_status.pop_front();
         checked++;
         if (v !== xv) begin
            $error("value: expected %0h, got %0h", xv, v);
            errors++;
         end
         if (e !== xe) begin
            $error("run_end: expected %0h, got %0h", xe, e);
            errors++;
         end
         if (c !== xc) begin
            $error("run_count: expected %0d, got %0d", xc, c);
            errors++;
         end
         if (s !== xs) begin
            $error("status: expected %0d, got %0d", xs, s);
            errors++;
         end
      endfunction

      function int outstanding();
         return want_value.size();
      endfunction
   endclass
endpackage
`default_nettype wire

>>> tb/interval_set_mark_and_next_free_core_tb.sv
`default_nettype none
module interval_set_mark_and_next_free_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import isnf_pkg::*;
   import isnf_tb_pkg::*;

   localparam int StallLimit = 20000;

   logic clock;
   logic reset;
   bit   calm;
   bit   hold_off;
   int   idle_cycles;
   int   sent;
   logic [31:0] base;

   isnf_req_if req ();
   isnf_rsp_if rsp ();

   run_table_scoreboard board = new();

   interval_set_mark_and_next_free_core dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic send_request(opcode_type op, logic [31:0] pos, logic [5:0] idx);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.position <= pos;
      req.run_index <= idx;
      do @(posedge clock); while (!req.ready);
      board.note_request(op, pos, idx);
      sent++;
      @(negedge clock);
   endtask

   task automatic random_request();
      int          pick;
      logic [31:0] pos;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         send_request(OP_CLEAR, $urandom, 6'($urandom));
      end else if (pick < 55) begin
         pos = ($urandom_range(0, 3) == 0) ? $urandom : base + $urandom_range(0, 200);
         send_request(OP_MARK, pos, 6'($urandom));
      end else if (pick < 80) begin
         pos = ($urandom_range(0, 3) == 0) ? $urandom : base + $urandom_range(0, 200) - 1;
         send_request(OP_NEXT, pos, 6'($urandom));
      end else begin
         send_request(OP_READ, $urandom, 6'($urandom));
      end
   endtask

   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_off = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_response(rsp.value, rsp.run_end, rsp.run_count, rsp.status);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("interval_set_mark_and_next_free_core_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.opcode = OP_CLEAR;
      req.position = '0;
      req.run_index = '0;
      reset = 1'b1;
      calm = 1'b0;
      hold_off = 1'b0;
      idle_cycles = 0;
      sent = 0;
      base = 32'd1000;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      send_request(OP_READ, '0, '0);
      send_request(OP_NEXT, PosTop, '0);
      send_request(OP_NEXT, '0, '0);
      send_request(OP_MARK, PosTop, '0);
      send_request(OP_NEXT, PosTop - 1, '0);
      send_request(OP_MARK, '0, '0);
      send_request(OP_MARK, '0, '0);
      send_request(OP_MARK, 32'd2, '0);
      send_request(OP_MARK, 32'd1, '0);
      send_request(OP_MARK, 32'd4, '0);
      send_request(OP_MARK, 32'd5, '0);
      send_request(OP_MARK, 32'd8, '0);
      send_request(OP_MARK, 32'd7, '0);
      send_request(OP_NEXT, 32'd0, '0);
      send_request(OP_NEXT, PosTop - 2, '0);
      send_request(OP_READ, '0, 6'd1);
      send_request(OP_READ, '0, 6'd63);
      send_request(OP_MARK, 32'hAAAA_5555, '0);
      send_request(OP_CLEAR, '0, '0);
      for (int i = 0; i < 65; i++) send_request(OP_MARK, 32'(2 * i), '0);
      send_request(OP_READ, '0, 6'd63);
      send_request(OP_MARK, 32'd1, '0);
      send_request(OP_MARK, 32'd500, '0);

      fork
         begin
            hold_off = 1'b1;
            for (int i = 0; i < 30; i++) random_request();
         end
      join
      for (int i = 0; i < 1900; i++) begin
         if (i % 300 == 0) base = $urandom;
         if (i == 1700) calm = 1'b1;
         random_request();
      end
      req.valid <= 1'b0;

      while (board.outstanding() > 0) @(negedge clock);
      repeat (600) @(negedge clock);
      $display("Sent %0d requests and checked %0d responses over clear, mark,",
               sent, board.checked);
      $display("next-free and read-run, including fuses, full table and overflow.");
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("interval_set_mark_and_next_free_core_tb: clean");
      end else begin
         $display("interval_set_mark_and_next_free_core_tb: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/isnf_pkg.sv
hw/rtl/isnf_if.sv
hw/rtl/isnf_ram.sv
hw/rtl/isnf_datapath.sv
hw/rtl/isnf_ctrl.sv
hw/rtl/interval_set_mark_and_next_free_core.sv
tb/isnf_tb_pkg.sv
tb/interval_set_mark_and_next_free_core_tb.sv
